// ===== design/dssm_pkg.sv =====
// ============================================================================
// dssm_pkg: shared types and constants for the dual stack core
// Holds the command and result records and the codes that the front end,
// the back end and the result queue have in common.
// ============================================================================
package dssm_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 16;

  // Result queue between the back end and the output ports.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Command queue between the front end and the back end.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  // Operation codes on the func input.
  localparam logic [FUNC_W-1:0] FUNC_PUSH_LO = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP_LO  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP_LO = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_HI = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POP_HI  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DUMP_HI = 3'd5;

  // Status codes on the result.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_DUMP
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic                     hi;     // 1 selects the stack that grows down
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } res_t;

  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } bk_state_t;

endpackage

// ===== design/dssm_front.sv =====
// ============================================================================
// dssm_front: input acceptance and command decoding
// Decodes func into a command record and holds up to two commands for the
// back end. Unused func codes are taken and dropped.
// ============================================================================
module dssm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [dssm_pkg::FUNC_W-1:0]         func,
  input  logic signed [dssm_pkg::DATA_W-1:0]  push_value,
  output logic                                cmd_valid,
  output dssm_pkg::cmd_t                      cmd,
  input  logic                                cmd_take
);

  dssm_pkg::cmd_t                    slots [dssm_pkg::CMD_DEPTH];
  logic [dssm_pkg::CMD_AW-1:0]       wptr;
  logic [dssm_pkg::CMD_AW-1:0]       rptr;
  logic [dssm_pkg::CMD_CW-1:0]       cnt;
  logic [dssm_pkg::CMD_CW-1:0]       cnt_next;
  dssm_pkg::cmd_t                    decoded;
  logic                              op_ok;
  logic                              enq;

  always_comb begin
    decoded.value = push_value;
    decoded.op    = dssm_pkg::OP_PUSH;
    decoded.hi    = 1'b0;
    op_ok         = 1'b1;
    unique case (func)
      dssm_pkg::FUNC_PUSH_LO: decoded.op = dssm_pkg::OP_PUSH;
      dssm_pkg::FUNC_POP_LO:  decoded.op = dssm_pkg::OP_POP;
      dssm_pkg::FUNC_DUMP_LO: decoded.op = dssm_pkg::OP_DUMP;
      dssm_pkg::FUNC_PUSH_HI: begin
        decoded.op = dssm_pkg::OP_PUSH;
        decoded.hi = 1'b1;
      end
      dssm_pkg::FUNC_POP_HI: begin
        decoded.op = dssm_pkg::OP_POP;
        decoded.hi = 1'b1;
      end
      dssm_pkg::FUNC_DUMP_HI: begin
        decoded.op = dssm_pkg::OP_DUMP;
        decoded.hi = 1'b1;
      end
      default: op_ok = 1'b0;
    endcase
  end

  assign full      = (cnt == dssm_pkg::CMD_CW'(dssm_pkg::CMD_DEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = slots[rptr];
  assign enq       = push && !full && op_ok;

  always_comb begin
    cnt_next = cnt;
    if (enq && !cmd_take) begin
      cnt_next = cnt + 1'b1;
    end else if (!enq && cmd_take) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      cnt <= cnt_next;
      if (enq) begin
        wptr <= wptr + 1'b1;
      end
      if (cmd_take) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wptr] <= decoded;
    end
  end

endmodule

// ===== design/dssm_back.sv =====
// ============================================================================
// dssm_back: stack execution unit
// Owns the shared word store and both stack counts. Carries out one command
// step per cycle given queue room; it registers each result before queuing.
// ============================================================================
module dssm_back #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  dssm_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  input  logic [dssm_pkg::OUT_CW-1:0]   out_count,
  output logic                          res_valid,
  output dssm_pkg::res_t                res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] TOP_ADDR  = AW'(DEPTH - 1);

  logic signed [dssm_pkg::DATA_W-1:0] store [DEPTH];
  logic signed [dssm_pkg::DATA_W-1:0] mem_q;

  dssm_pkg::bk_state_t state;
  dssm_pkg::bk_state_t state_next;
  logic [CW-1:0]       low_count;
  logic [CW-1:0]       low_count_next;
  logic [CW-1:0]       high_count;
  logic [CW-1:0]       high_count_next;
  logic [AW-1:0]       ptr;
  logic [AW-1:0]       ptr_next;

  logic                          room;
  logic                          stacks_full;
  logic [CW-1:0]                 cnt_sel;
  logic [AW-1:0]                 first;
  logic [AW-1:0]                 sel_addr;
  logic                          at_end;
  logic [AW-1:0]                 step_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          iss;
  logic [dssm_pkg::STATUS_W-1:0] iss_status;
  logic                          iss_last;
  logic                          iss_mem;
  logic [dssm_pkg::STATUS_W-1:0] res_status;
  logic                          res_last;
  logic                          res_mem;

  // A step may issue only if its result is sure of a slot in the queue.
  assign room = ({1'b0, out_count} + {{dssm_pkg::OUT_CW{1'b0}}, res_valid})
                < (dssm_pkg::OUT_CW + 1)'(dssm_pkg::OUT_DEPTH);

  assign stacks_full = ({1'b0, low_count} + {1'b0, high_count}) >= DEPTH_SUM;
  assign cnt_sel     = cmd.hi ? high_count : low_count;
  assign first       = cmd.hi ? AW'(DEPTH_C - high_count) : AW'(low_count - CW'(1));
  assign sel_addr    = (state == dssm_pkg::BK_DUMP) ? ptr : first;
  assign at_end      = cmd.hi ? (sel_addr == TOP_ADDR) : (sel_addr == '0);
  assign step_addr   = cmd.hi ? (sel_addr + 1'b1) : (sel_addr - 1'b1);

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    low_count_next  = low_count;
    high_count_next = high_count;
    cmd_take        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = AW'(low_count);
    rd_en           = 1'b0;
    rd_addr         = sel_addr;
    iss             = 1'b0;
    iss_status      = dssm_pkg::ST_OK;
    iss_last        = 1'b1;
    iss_mem         = 1'b0;
    unique case (state)
      dssm_pkg::BK_RUN: begin
        if (cmd_valid && room) begin
          iss = 1'b1;
          unique case (cmd.op)
            dssm_pkg::OP_PUSH: begin
              cmd_take = 1'b1;
              if (stacks_full) begin
                iss_status = dssm_pkg::ST_FULL;
              end else if (cmd.hi) begin
                wr_en           = 1'b1;
                wr_addr         = AW'(DEPTH_C - CW'(1) - high_count);
                high_count_next = high_count + 1'b1;
              end else begin
                wr_en          = 1'b1;
                low_count_next = low_count + 1'b1;
              end
            end
            dssm_pkg::OP_POP: begin
              cmd_take = 1'b1;
              if (cnt_sel == '0) begin
                iss_status = dssm_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                iss_mem = 1'b1;
                if (cmd.hi) begin
                  high_count_next = high_count - 1'b1;
                end else begin
                  low_count_next = low_count - 1'b1;
                end
              end
            end
            dssm_pkg::OP_DUMP: begin
              if (cnt_sel == '0) begin
                cmd_take   = 1'b1;
                iss_status = dssm_pkg::ST_EMPTY;
              end else begin
                rd_en    = 1'b1;
                iss_mem  = 1'b1;
                iss_last = at_end;
                if (at_end) begin
                  cmd_take = 1'b1;
                end else begin
                  state_next = dssm_pkg::BK_DUMP;
                  ptr_next   = step_addr;
                end
              end
            end
            default: cmd_take = 1'b1;
          endcase
        end
      end
      dssm_pkg::BK_DUMP: begin
        if (room) begin
          iss      = 1'b1;
          rd_en    = 1'b1;
          iss_mem  = 1'b1;
          iss_last = at_end;
          if (at_end) begin
            cmd_take   = 1'b1;
            state_next = dssm_pkg::BK_RUN;
          end else begin
            ptr_next = step_addr;
          end
        end
      end
      default: state_next = dssm_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dssm_pkg::BK_RUN;
      low_count  <= '0;
      high_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      low_count  <= low_count_next;
      high_count <= high_count_next;
      res_valid  <= iss;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= iss_status;
    res_last   <= iss_last;
    res_mem    <= iss_mem;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      mem_q <= store[rd_addr];
    end
  end

  assign res.data   = res_mem ? mem_q : '0;
  assign res.status = res_status;
  assign res.last   = res_last;

endmodule

// ===== design/dssm_out_fifo.sv =====
// ============================================================================
// dssm_out_fifo: result queue
// Small queue of finished results; it reports its fill so that the back end
// never issues more than it can hold.
// ============================================================================
module dssm_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_valid,
  input  dssm_pkg::res_t               wr_res,
  input  logic                         rd_pop,
  output logic                         empty,
  output dssm_pkg::res_t               head,
  output logic [dssm_pkg::OUT_CW-1:0]  count
);

  dssm_pkg::res_t               slots [dssm_pkg::OUT_DEPTH];
  logic [dssm_pkg::OUT_AW-1:0]  wptr;
  logic [dssm_pkg::OUT_AW-1:0]  rptr;
  logic [dssm_pkg::OUT_CW-1:0]  count_next;
  logic                         deq;

  assign empty = (count == '0);
  assign head  = slots[rptr];
  assign deq   = rd_pop && !empty;

  always_comb begin
    count_next = count;
    if (wr_valid && !deq) begin
      count_next = count + 1'b1;
    end else if (!wr_valid && deq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (wr_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (deq) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wptr] <= wr_res;
    end
  end

endmodule

// ===== design/dual_stack_shared_memory_core.sv =====
// ============================================================================
// dual_stack_shared_memory_core: two stacks sharing one word store
// Top level joining the command front end, the execution back end and the
// result queue.
// ============================================================================
// Usage. Both sides look like a queue. An item (func, push_value) transfers
// at a rising edge with push high and full low. A result (data, status,
// last) is on the result ports while empty is low and transfers at a rising
// edge with pop high and empty low; results leave in order, and last marks
// the final result of each item.
// Each push or pop gives one result; a dump gives one result per entry of
// the chosen stack, top first, or a single empty result for an empty stack.
// Unused func codes are accepted and give no result.
// An item enters the command queue at its transfer edge; the back end then
// reads the store into its result register, and the result queue takes the
// result from there. Throughput: the back end retires one push or pop per
// cycle and streams one dump entry per cycle while the result queue has
// room; a dump holds the back end until its last entry. The single read port
// of the store sets this rate.
// Reset clears both stack counts and all queues; the store keeps whatever it
// held, and no word is read before it has been written.
// When the receiver stalls, results build up in a four-entry queue; the back
// end then stops, the two-entry command queue fills and full is raised.
// ============================================================================
module dual_stack_shared_memory_core #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [dssm_pkg::FUNC_W-1:0]         func,
  input  logic signed [dssm_pkg::DATA_W-1:0]  push_value,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [dssm_pkg::DATA_W-1:0]  data,
  output logic [dssm_pkg::STATUS_W-1:0]       status,
  output logic                                last
);

  // Command path from the front end to the back end.
  logic            cmd_valid;
  dssm_pkg::cmd_t  cmd;
  logic            cmd_take;

  // Result path from the back end into the result queue.
  logic                          res_valid;
  dssm_pkg::res_t                res;
  dssm_pkg::res_t                head;
  logic [dssm_pkg::OUT_CW-1:0]   out_count;

  dssm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // The back end only issues a step when the result queue has a slot free
  // for it, counting the result still in its own output register.
  dssm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res)
  );

  dssm_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_res   (res),
    .rd_pop   (pop),
    .empty    (empty),
    .head     (head),
    .count    (out_count)
  );

  assign data   = head.data;
  assign status = head.status;
  assign last   = head.last;

endmodule
